// ===== rtl/mscp_pkg.sv =====
// Shared types and constants for the MPEG start code parser.
package mscp_pkg;

  // Parse phase of the scanner
  typedef enum logic [1:0] {
    PH_SCAN,
    PH_CODE,
    PH_SEQ,
    PH_PIC
  } phase_t;

  // Event kind codes
  localparam logic [2:0] EV_PACK    = 3'd0;
  localparam logic [2:0] EV_SYSTEM  = 3'd1;
  localparam logic [2:0] EV_SEQ_HDR = 3'd2;
  localparam logic [2:0] EV_GOP     = 3'd3;
  localparam logic [2:0] EV_PICTURE = 3'd4;
  localparam logic [2:0] EV_SLICE   = 3'd5;
  localparam logic [2:0] EV_VIDEO   = 3'd6;
  localparam logic [2:0] EV_AUDIO   = 3'd7;

  // Start code values and ranges
  localparam logic [7:0] PREFIX_LAST  = 8'h01;
  localparam logic [7:0] CODE_PACK    = 8'hBA;
  localparam logic [7:0] CODE_SYSTEM  = 8'hBB;
  localparam logic [7:0] CODE_SEQ_HDR = 8'hB3;
  localparam logic [7:0] CODE_GOP     = 8'hB8;
  localparam logic [7:0] CODE_PICTURE = 8'h00;
  localparam logic [7:0] SLICE_LO     = 8'h01;
  localparam logic [7:0] SLICE_HI     = 8'hAF;
  localparam logic [7:0] AUDIO_LO     = 8'hC0;
  localparam logic [7:0] AUDIO_HI     = 8'hDF;
  localparam logic [7:0] VIDEO_LO     = 8'hE0;
  localparam logic [7:0] VIDEO_HI     = 8'hEF;

  // Header byte counts and valid code ranges
  localparam logic [2:0] SEQ_BYTES = 3'd4;
  localparam logic [2:0] PIC_BYTES = 3'd2;
  localparam logic [3:0] RATE_MIN  = 4'd1;
  localparam logic [3:0] RATE_MAX  = 4'd8;
  localparam logic [2:0] PTYPE_MIN = 3'd1;
  localparam logic [2:0] PTYPE_MAX = 3'd3;
  localparam logic [1:0] FILL_FULL = 2'd2;

  // One result item
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  code_value;
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [3:0]  rate_code;
    logic [1:0]  picture_kind;
  } event_t;

  // Result handed from the parse stage to the output buffer
  typedef struct packed {
    logic   valid;
    event_t data;
  } event_push_t;

endpackage

// ===== rtl/mscp_byte_if.sv =====
// Byte stream channel: valid/ready handshake carrying one stream byte.
interface mscp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/mscp_event_if.sv =====
// Event channel: valid/ready handshake carrying one parsed start code event.
interface mscp_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [7:0]  code_value;
  logic [11:0] frame_width;
  logic [11:0] frame_height;
  logic [3:0]  rate_code;
  logic [1:0]  picture_kind;

  modport source (output valid, output event_kind, output code_value, output frame_width,
                  output frame_height, output rate_code, output picture_kind, input ready);
  modport sink (input valid, input event_kind, input code_value, input frame_width,
                input frame_height, input rate_code, input picture_kind, output ready);
endinterface

// ===== rtl/mscp_parse.sv =====
// Input register and single-pass start code parse stage with scanner state.
module mscp_parse import mscp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mscp_byte_if.sink   stream,
  input  logic        buf_ready,
  output event_push_t push
);

  logic        in_valid;
  logic [7:0]  in_byte;

  phase_t      phase, phase_next;
  logic [15:0] recent, recent_next;
  logic [1:0]  fill, fill_next;
  logic [2:0]  bytes_left, bytes_left_next;
  logic [23:0] hdr, hdr_next;

  logic        advance;
  logic        res_valid;
  event_t      res;
  logic [3:0]  rate;
  logic [2:0]  ptype;

  assign advance      = in_valid && buf_ready;
  assign stream.ready = !in_valid || buf_ready;
  assign rate         = in_byte[3:0];
  assign ptype        = in_byte[5:3];

  // Hold the accepted byte until the parse stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      in_byte <= stream.data_byte;
    end
  end

  // Classify the byte and compute next scanner state
  always_comb begin
    phase_next      = phase;
    recent_next     = recent;
    fill_next       = fill;
    bytes_left_next = bytes_left;
    hdr_next        = hdr;
    res_valid       = 1'b0;
    res             = '0;
    case (phase)
      PH_SCAN: begin
        if (fill == FILL_FULL && recent == 16'h0000 && in_byte == PREFIX_LAST) begin
          recent_next = '0;
          fill_next   = '0;
          phase_next  = PH_CODE;
        end else begin
          recent_next = {recent[7:0], in_byte};
          fill_next   = (fill == FILL_FULL) ? FILL_FULL : fill + 2'd1;
        end
      end
      PH_CODE: begin
        recent_next     = '0;
        fill_next       = '0;
        phase_next      = PH_SCAN;
        bytes_left_next = '0;
        res.code_value  = in_byte;
        if (in_byte == CODE_PACK) begin
          res_valid      = 1'b1;
          res.event_kind = EV_PACK;
        end else if (in_byte == CODE_SYSTEM) begin
          res_valid      = 1'b1;
          res.event_kind = EV_SYSTEM;
        end else if (in_byte == CODE_GOP) begin
          res_valid      = 1'b1;
          res.event_kind = EV_GOP;
        end else if (in_byte == CODE_SEQ_HDR) begin
          phase_next      = PH_SEQ;
          bytes_left_next = SEQ_BYTES;
        end else if (in_byte == CODE_PICTURE) begin
          phase_next      = PH_PIC;
          bytes_left_next = PIC_BYTES;
        end else if (in_byte >= SLICE_LO && in_byte <= SLICE_HI) begin
          res_valid      = 1'b1;
          res.event_kind = EV_SLICE;
        end else if (in_byte >= AUDIO_LO && in_byte <= AUDIO_HI) begin
          res_valid      = 1'b1;
          res.event_kind = EV_AUDIO;
        end else if (in_byte >= VIDEO_LO && in_byte <= VIDEO_HI) begin
          res_valid      = 1'b1;
          res.event_kind = EV_VIDEO;
        end
      end
      PH_SEQ: begin
        hdr_next = {hdr[15:0], in_byte};
        if (bytes_left > 3'd1) begin
          bytes_left_next = bytes_left - 3'd1;
        end else begin
          recent_next     = '0;
          fill_next       = '0;
          phase_next      = PH_SCAN;
          bytes_left_next = '0;
          if (rate >= RATE_MIN && rate <= RATE_MAX) begin
            res_valid        = 1'b1;
            res.event_kind   = EV_SEQ_HDR;
            res.code_value   = CODE_SEQ_HDR;
            res.frame_width  = {hdr[23:16], hdr[15:12]};
            res.frame_height = hdr[11:0];
            res.rate_code    = rate;
          end
        end
      end
      PH_PIC: begin
        hdr_next = {hdr[15:0], in_byte};
        if (bytes_left > 3'd1) begin
          bytes_left_next = bytes_left - 3'd1;
        end else begin
          recent_next     = '0;
          fill_next       = '0;
          phase_next      = PH_SCAN;
          bytes_left_next = '0;
          if (ptype >= PTYPE_MIN && ptype <= PTYPE_MAX) begin
            res_valid        = 1'b1;
            res.event_kind   = EV_PICTURE;
            res.code_value   = CODE_PICTURE;
            res.picture_kind = ptype[1:0];
          end
        end
      end
      default: begin
        phase_next = PH_SCAN;
      end
    endcase
  end

  // Advance scanner state when the byte is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SCAN;
      recent     <= '0;
      fill       <= '0;
      bytes_left <= '0;
      hdr        <= '0;
    end else if (advance) begin
      phase      <= phase_next;
      recent     <= recent_next;
      fill       <= fill_next;
      bytes_left <= bytes_left_next;
      hdr        <= hdr_next;
    end
  end

  assign push.valid = advance && res_valid;
  assign push.data  = res;

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("window fill out of range");

  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SCAN || phase == PH_CODE) |-> bytes_left == 3'd0)
    else $error("header byte count left over outside header phase");

  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SEQ || phase == PH_PIC) |-> (bytes_left != 3'd0 && bytes_left <= SEQ_BYTES))
    else $error("header byte count out of range");

  a_code_after_prefix: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CODE) |-> (fill == 2'd0 && recent == 16'h0000))
    else $error("window not emptied after prefix");

endmodule

// ===== rtl/mscp_out_buf.sv =====
// Two-entry output buffer (result register plus skid entry) for parsed events.
module mscp_out_buf import mscp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  event_push_t  push,
  output logic         buf_ready,
  mscp_event_if.source events
);

  logic   main_valid;
  logic   skid_valid;
  event_t main_data;
  event_t skid_data;
  logic   pop;

  assign pop       = main_valid && events.ready;
  assign buf_ready = !skid_valid;

  // Track occupancy of result and skid entries
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Move payload into the result register or park it in the skid entry
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_data <= skid_data;
      end
    end else if (push.valid) begin
      if (!main_valid || pop) begin
        main_data <= push.data;
      end else begin
        skid_data <= push.data;
      end
    end
  end

  assign events.valid        = main_valid;
  assign events.event_kind   = main_data.event_kind;
  assign events.code_value   = main_data.code_value;
  assign events.frame_width  = main_data.frame_width;
  assign events.frame_height = main_data.frame_height;
  assign events.rate_code    = main_data.rate_code;
  assign events.picture_kind = main_data.picture_kind;

  a_skid_implies_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry held while result register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push.valid)
    else $error("item pushed into full output buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (main_valid && !skid_valid))
    else $error("skid entry lost on drain");

endmodule

// ===== rtl/mpeg_start_code_parser.sv =====
// MPEG start code parser top level: byte stream in, start code events out.
// An accepted byte is held in the input register; its result item is then offered from the output buffer.
// Throughput: one byte per cycle, sustained while the event sink keeps up.
// The input register feeds one combinational parse pass; a two-entry output
// buffer lets the next byte be taken while an event still waits.
// Reset (synchronous, active high): window empty, scanning for the prefix.
module mpeg_start_code_parser import mscp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  mscp_byte_if.sink    stream,
  mscp_event_if.source events
);

  event_push_t push;
  logic        buf_ready;

  // Parse stage
  mscp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .buf_ready (buf_ready),
    .push      (push)
  );

  // Output buffer
  mscp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .buf_ready (buf_ready),
    .events    (events)
  );

endmodule

// ===== test/testbench.sv =====
// Testbench for the MPEG start code parser: random byte streams against a scoreboard.
module testbench import mscp_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 200;
  localparam int unsigned MAX_REPORTS = 10;

  // Predict parser events from accepted bytes and match them against the output
  class start_code_scoreboard;
    event_t      pending_events[$];
    logic [15:0] window_bytes;
    logic [1:0]  window_count;
    phase_t      phase;
    logic [2:0]  header_left;
    logic [23:0] header_bytes;
    int unsigned failures;

    function new();
      clear_window();
      header_bytes = '0;
      failures = 0;
    endfunction

    function void clear_window();
      window_bytes = '0;
      window_count = '0;
      phase = PH_SCAN;
      header_left = '0;
    endfunction

    // Advance the parse state by one byte; queue the event it reports, if any
    function void note_byte(logic [7:0] b);
      event_t     ev;
      logic       hit;
      logic [3:0] rate;
      logic [2:0] ptype;
      ev = '0;
      hit = 1'b0;
      case (phase)
        PH_SCAN: begin
          if (window_count == FILL_FULL && window_bytes == 16'h0000 && b == PREFIX_LAST) begin
            clear_window();
            phase = PH_CODE;
          end else begin
            window_bytes = {window_bytes[7:0], b};
            if (window_count != FILL_FULL) window_count = window_count + 2'd1;
          end
        end
        PH_CODE: begin
          clear_window();
          ev.code_value = b;
          hit = 1'b1;
          if (b == CODE_PACK) ev.event_kind = EV_PACK;
          else if (b == CODE_SYSTEM) ev.event_kind = EV_SYSTEM;
          else if (b == CODE_GOP) ev.event_kind = EV_GOP;
          else if (b == CODE_SEQ_HDR) begin
            hit = 1'b0;
            phase = PH_SEQ;
            header_left = SEQ_BYTES;
          end else if (b == CODE_PICTURE) begin
            hit = 1'b0;
            phase = PH_PIC;
            header_left = PIC_BYTES;
          end else if (b >= SLICE_LO && b <= SLICE_HI) ev.event_kind = EV_SLICE;
          else if (b >= AUDIO_LO && b <= AUDIO_HI) ev.event_kind = EV_AUDIO;
          else if (b >= VIDEO_LO && b <= VIDEO_HI) ev.event_kind = EV_VIDEO;
          else hit = 1'b0;
        end
        PH_SEQ: begin
          if (header_left > 3'd1) begin
            header_bytes = {header_bytes[15:0], b};
            header_left = header_left - 3'd1;
          end else begin
            rate = b[3:0];
            ev.event_kind = EV_SEQ_HDR;
            ev.code_value = CODE_SEQ_HDR;
            ev.frame_width = {header_bytes[23:16], header_bytes[15:12]};
            ev.frame_height = header_bytes[11:0];
            ev.rate_code = rate;
            hit = (rate >= RATE_MIN && rate <= RATE_MAX);
            header_bytes = {header_bytes[15:0], b};
            clear_window();
          end
        end
        default: begin
          header_bytes = {header_bytes[15:0], b};
          if (header_left > 3'd1) begin
            header_left = header_left - 3'd1;
          end else begin
            ptype = b[5:3];
            ev.event_kind = EV_PICTURE;
            ev.code_value = CODE_PICTURE;
            ev.picture_kind = ptype[1:0];
            hit = (ptype >= PTYPE_MIN && ptype <= PTYPE_MAX);
            clear_window();
          end
        end
      endcase
      if (hit) pending_events.push_back(ev);
    endfunction

    // Compare one delivered event with the oldest predicted one
    function void check_event(event_t got);
      event_t exp;
      if (pending_events.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected event: kind %0d code %02h w %0d h %0d rate %0d pic %0d",
                   got.event_kind, got.code_value, got.frame_width, got.frame_height,
                   got.rate_code, got.picture_kind);
        return;
      end
      exp = pending_events.pop_front();
      if (got.event_kind !== exp.event_kind || got.code_value !== exp.code_value ||
          got.frame_width !== exp.frame_width || got.frame_height !== exp.frame_height ||
          got.rate_code !== exp.rate_code || got.picture_kind !== exp.picture_kind) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("event mismatch: expected kind %0d code %02h w %0d h %0d rate %0d pic %0d",
                   exp.event_kind, exp.code_value, exp.frame_width, exp.frame_height,
                   exp.rate_code, exp.picture_kind);
          $display("                got      kind %0d code %02h w %0d h %0d rate %0d pic %0d",
                   got.event_kind, got.code_value, got.frame_width, got.frame_height,
                   got.rate_code, got.picture_kind);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  start_code_scoreboard sb = new();

  mscp_byte_if  byte_ch ();
  mscp_event_if event_ch ();

  mpeg_start_code_parser dut (
    .clk    (clk),
    .rst    (rst),
    .stream (byte_ch),
    .events (event_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Stall the event sink at random
  always @(posedge clk) begin
    event_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Note accepted bytes and check accepted events
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_ch.valid && byte_ch.ready) sb.note_byte(byte_ch.data_byte);
      if (event_ch.valid && event_ch.ready)
        sb.check_event({event_ch.event_kind, event_ch.code_value, event_ch.frame_width,
                        event_ch.frame_height, event_ch.rate_code, event_ch.picture_kind});
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold it until taken
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.data_byte <= b;
    do @(posedge clk); while (!byte_ch.ready);
    sent_count++;
  endtask

  task automatic send_prefix();
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(PREFIX_LAST);
  endtask

  // Hold the stream until every predicted event has come out
  task automatic drain();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending_events.size() != 0);
  endtask

  // Mostly well-formed start codes with random content, some broken prefixes and noise
  task automatic send_random_chunk();
    int unsigned pick;
    logic [7:0]  code;
    logic [3:0]  rate;
    logic [2:0]  ptype;
    logic [7:0]  pbyte;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    pick = $urandom_range(99);
    if (pick < 80) begin
      send_prefix();
      case ($urandom_range(8))
        0: send_byte(CODE_PACK);
        1: send_byte(CODE_SYSTEM);
        2: send_byte(CODE_GOP);
        3: begin
          // sequence header, sometimes with a rate code that reports nothing
          if ($urandom_range(4) == 0)
            rate = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
          else
            rate = 4'($urandom_range(1, 8));
          send_byte(CODE_SEQ_HDR);
          repeat (3) send_byte(8'($urandom_range(255)));
          send_byte({4'($urandom_range(15)), rate});
        end
        4: begin
          // picture, sometimes with a coding type that reports nothing
          if ($urandom_range(4) == 0)
            ptype = ($urandom_range(1) == 0) ? 3'd0 : 3'($urandom_range(4, 7));
          else
            ptype = 3'($urandom_range(1, 3));
          pbyte = 8'($urandom_range(255));
          pbyte[5:3] = ptype;
          send_byte(CODE_PICTURE);
          send_byte(8'($urandom_range(255)));
          send_byte(pbyte);
        end
        5: send_byte(8'($urandom_range(SLICE_LO, SLICE_HI)));
        6: send_byte(8'($urandom_range(AUDIO_LO, AUDIO_HI)));
        7: send_byte(8'($urandom_range(VIDEO_LO, VIDEO_HI)));
        default: begin
          // reserved code values
          do code = 8'($urandom_range(8'hB0, 8'hFF));
          while (code == CODE_PACK || code == CODE_SYSTEM || code == CODE_GOP ||
                 code == CODE_SEQ_HDR || (code >= AUDIO_LO && code <= VIDEO_HI));
          send_byte(code);
        end
      endcase
    end else if (pick < 90) begin
      send_byte(8'h00);
      if ($urandom_range(1) == 0) begin
        send_byte(PREFIX_LAST);
        send_byte(8'($urandom_range(255)));
      end else begin
        send_byte(8'h00);
        send_byte(8'($urandom_range(2, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct);
    int unsigned start;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    start = sent_count;
    while (sent_count - start < PHASE_BYTES) send_random_chunk();
  endtask

  // Stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("mpeg_start_code_parser regression: fail");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    byte_ch.valid <= 1'b0;
    byte_ch.data_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 10;
    snk_idle_pct = 55;
    // pack, then a sequence header with every size bit set and the top rate code
    send_prefix();
    send_byte(CODE_PACK);
    send_prefix();
    send_byte(CODE_SEQ_HDR);
    repeat (3) send_byte(8'hFF);
    send_byte(8'hF8);
    // B picture, then a reserved code that reports nothing
    send_prefix();
    send_byte(CODE_PICTURE);
    send_byte(8'h00);
    send_byte(8'h18);
    send_prefix();
    send_byte(8'hFF);
    // extra zero ahead of the prefix still finds it
    send_byte(8'h00);
    send_prefix();
    send_byte(VIDEO_LO);

    run_phase(10, 55);
    drain();
    run_phase(55, 10);
    drain();
    run_phase(0, 0);
    drain();
    repeat (10) @(posedge clk);

    if (sb.failures == 0 && sb.pending_events.size() == 0) begin
      $display("mpeg_start_code_parser regression: pass");
    end else begin
      $display("mpeg_start_code_parser regression: fail");
    end
    $finish;
  end

endmodule
